// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg
// Shared widths, codes and state type for the keyed entry table.
// ----------------------------------------------------------------------------
package ket_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 7;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_DUP       = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_ZERO_KEY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2
    } t_state;

endpackage

// File: src/ket_item_if.sv
// ----------------------------------------------------------------------------
// ket_item_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
interface ket_item_if;
    logic                         valid;
    logic                         ready;
    logic [ket_pkg::OP_W-1:0]     operation;
    logic [ket_pkg::KEY_W-1:0]    key;
    logic [ket_pkg::KEY_W-1:0]    new_key;
    logic [ket_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output key, output new_key,
                    output value, input ready);
    modport sink   (input valid, input operation, input key, input new_key,
                    input value, output ready);
endinterface

// File: src/ket_result_if.sv
// ----------------------------------------------------------------------------
// ket_result_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
interface ket_result_if;
    logic                         valid;
    logic                         ready;
    logic [ket_pkg::STAT_W-1:0]   status;
    logic [ket_pkg::KEY_W-1:0]    found_key;
    logic [ket_pkg::VALUE_W-1:0]  found_value;
    logic [ket_pkg::CAP_W-1:0]    entry_total;

    modport source (output valid, output status, output found_key,
                    output found_value, output entry_total, input ready);
    modport sink   (input valid, input status, input found_key,
                    input found_value, input entry_total, output ready);
endinterface

// File: src/ket_cfg_if.sv
// ----------------------------------------------------------------------------
// ket_cfg_if
// Capacity register write channel.
// ----------------------------------------------------------------------------
interface ket_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ket_pkg::CAP_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/keyed_entry_table.sv
// ----------------------------------------------------------------------------
// keyed_entry_table
// Fixed-capacity key/value table. Keys and values live in two RAMs; slot
// occupancy lives in flip-flops. Each request scans the active slots once,
// then writes back and loads the response register.
//
//   channel   dir  handshake            payload
//   i_item    in   valid/ready          operation, key, new_key, value
//   o_result  out  valid/ready          status, found_key, found_value,
//                                       entry_total
//   i_cfg     in   valid/ready          data (capacity)
//
// A request goes through N reads, N being the active slot count, capacity
// capped at 64, then read latency, scan close and write-back. The next
// request is accepted only after write-back, once the block is back in idle.
// Synchronous active-low reset empties the table and sets capacity to 64;
// a capacity write also empties it. A stalled response holds in the
// output register; the next request is accepted and then waits in write-back.
// ----------------------------------------------------------------------------
module keyed_entry_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ket_item_if.sink       i_item,
    ket_result_if.source   o_result,
    ket_cfg_if.sink        i_cfg
);

    ket_pkg::t_state                  r_state, n_state;
    logic [ket_pkg::CAP_W-1:0]        r_cap;
    logic [ket_pkg::CNT_W-1:0]        r_count, n_count;
    logic [ket_pkg::DEPTH-1:0]        r_occ;

    ket_pkg::t_op                     r_op;
    logic [ket_pkg::KEY_W-1:0]        r_key;
    logic [ket_pkg::KEY_W-1:0]        r_new_key;
    logic [ket_pkg::VALUE_W-1:0]      r_value;

    logic [ket_pkg::CNT_W-1:0]        r_rd_idx;
    logic                             r_chk_vld;
    logic [ket_pkg::ADDR_W-1:0]       r_chk_idx;
    logic                             r_chk_occ;

    logic                             r_key_hit;
    logic [ket_pkg::ADDR_W-1:0]       r_key_slot;
    logic [ket_pkg::VALUE_W-1:0]      r_found_val;
    logic                             r_new_hit;
    logic                             r_free_hit;
    logic [ket_pkg::ADDR_W-1:0]       r_free_slot;

    logic                             r_out_valid;
    ket_pkg::t_status                 r_out_status;
    logic [ket_pkg::KEY_W-1:0]        r_out_fkey;
    logic [ket_pkg::VALUE_W-1:0]      r_out_fval;
    logic [ket_pkg::CNT_W-1:0]        r_out_total;

    logic [ket_pkg::CNT_W-1:0]        active;
    logic                             item_ready;
    logic                             accept;
    logic                             rd_en;
    logic                             scan_done;
    logic                             load;
    logic                             cfg_wr;

    logic [ket_pkg::KEY_W-1:0]        rd_key;
    logic [ket_pkg::VALUE_W-1:0]      rd_val;
    logic                             match_key;
    logic                             match_new;

    ket_pkg::t_status                 status;
    logic                             wr_en;
    logic [ket_pkg::ADDR_W-1:0]       wr_addr;
    logic [ket_pkg::KEY_W-1:0]        wr_key;
    logic                             occ_set;
    logic                             occ_clr;
    logic [ket_pkg::KEY_W-1:0]        fkey;
    logic [ket_pkg::VALUE_W-1:0]      fval;

    assign active = (int'(r_cap) > ket_pkg::DEPTH) ? ket_pkg::CNT_W'(ket_pkg::DEPTH)
                                                   : ket_pkg::CNT_W'(r_cap);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ket_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = ket_pkg::ST_SCAN;
                end
            end
            ket_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = ket_pkg::ST_WRITE;
                end
            end
            ket_pkg::ST_WRITE: begin
                if (load) begin
                    n_state = ket_pkg::ST_IDLE;
                end
            end
            default: n_state = ket_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        item_ready = 1'b0;
        rd_en      = 1'b0;
        scan_done  = 1'b0;
        load       = 1'b0;
        unique case (r_state)
            ket_pkg::ST_IDLE: begin
                item_ready = 1'b1;
            end
            ket_pkg::ST_SCAN: begin
                rd_en     = (r_rd_idx < active);
                scan_done = (r_rd_idx >= active) && !r_chk_vld;
            end
            ket_pkg::ST_WRITE: begin
                load = !r_out_valid || o_result.ready;
            end
            default: begin
                item_ready = 1'b0;
            end
        endcase
    end

    assign i_item.ready = item_ready;
    assign accept       = i_item.valid && item_ready;
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr       = i_cfg.valid;

    ket_ram #(.WIDTH(ket_pkg::KEY_W), .DEPTH(ket_pkg::DEPTH)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[ket_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_key)
    );

    ket_ram #(.WIDTH(ket_pkg::VALUE_W), .DEPTH(ket_pkg::DEPTH)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[ket_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_val)
    );

    assign match_key = r_chk_vld && r_chk_occ && (rd_key == r_key);
    assign match_new = r_chk_vld && r_chk_occ && (rd_key == r_new_key);

    // Write-back decision
    always_comb begin
        status  = ket_pkg::STATUS_OK;
        wr_en   = 1'b0;
        wr_addr = r_key_slot;
        wr_key  = r_new_key;
        occ_set = 1'b0;
        occ_clr = 1'b0;
        fkey    = '0;
        fval    = '0;
        n_count = r_count;
        priority if (r_key == '0 ||
                     (r_op == ket_pkg::OP_UPDATE && r_new_key == '0)) begin
            status = ket_pkg::STATUS_ZERO_KEY;
        end else begin
            unique case (r_op)
                ket_pkg::OP_ADD: begin
                    priority if (r_count >= active) begin
                        status = ket_pkg::STATUS_FULL;
                    end else if (r_key_hit) begin
                        status = ket_pkg::STATUS_DUP;
                    end else if (!r_free_hit) begin
                        status = ket_pkg::STATUS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_free_slot;
                        wr_key  = r_key;
                        occ_set = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                ket_pkg::OP_DELETE: begin
                    if (!r_key_hit) begin
                        status = ket_pkg::STATUS_NOT_FOUND;
                    end else begin
                        occ_clr = 1'b1;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                ket_pkg::OP_UPDATE: begin
                    priority if (r_new_hit) begin
                        status = ket_pkg::STATUS_DUP;
                    end else if (!r_key_hit) begin
                        status = ket_pkg::STATUS_NOT_FOUND;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                ket_pkg::OP_GET: begin
                    if (!r_key_hit) begin
                        status = ket_pkg::STATUS_NOT_FOUND;
                    end else begin
                        fkey = r_key;
                        fval = r_found_val;
                    end
                end
                default: status = ket_pkg::STATUS_NOT_FOUND;
            endcase
        end
        if (!load) begin
            wr_en   = 1'b0;
            occ_set = 1'b0;
            occ_clr = 1'b0;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ket_pkg::ST_IDLE;
            r_cap       <= ket_pkg::CAP_RESET;
            r_count     <= '0;
            r_occ       <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_hit   <= 1'b0;
            r_new_hit   <= 1'b0;
            r_free_hit  <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= rd_en;

            if (accept) begin
                r_op       <= ket_pkg::t_op'(i_item.operation);
                r_key      <= i_item.key;
                r_new_key  <= i_item.new_key;
                r_value    <= i_item.value;
                r_rd_idx   <= '0;
                r_key_hit  <= 1'b0;
                r_new_hit  <= 1'b0;
                r_free_hit <= 1'b0;
            end

            if (rd_en) begin
                r_rd_idx  <= r_rd_idx + 1'b1;
                r_chk_idx <= r_rd_idx[ket_pkg::ADDR_W-1:0];
                r_chk_occ <= r_occ[r_rd_idx[ket_pkg::ADDR_W-1:0]];
            end

            // Keep the lowest key-match slot and the lowest free slot
            if (match_key && !r_key_hit) begin
                r_key_hit   <= 1'b1;
                r_key_slot  <= r_chk_idx;
                r_found_val <= rd_val;
            end
            if (match_new && !(match_key && !r_key_hit)) begin
                r_new_hit <= 1'b1;
            end
            if (r_chk_vld && !r_chk_occ && !r_free_hit) begin
                r_free_hit  <= 1'b1;
                r_free_slot <= r_chk_idx;
            end

            // Capacity write empties the table
            if (cfg_wr) begin
                r_cap   <= i_cfg.data;
                r_occ   <= '0;
                r_count <= '0;
            end else begin
                r_count <= n_count;
                if (occ_set) begin
                    r_occ[wr_addr] <= 1'b1;
                end else if (occ_clr) begin
                    r_occ[r_key_slot] <= 1'b0;
                end
            end

            if (load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= status;
                r_out_fkey   <= fkey;
                r_out_fval   <= fval;
                r_out_total  <= n_count;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.found_key   = r_out_fkey;
    assign o_result.found_value = r_out_fval;
    assign o_result.entry_total = ket_pkg::CAP_W'(r_out_total);

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_count_matches_occ, i_clk, i_rst_n, 1'b1, $countones(r_occ) == int'(r_count))
    `ASSERT_IMPLIES(a_no_read_in_idle, i_clk, i_rst_n, r_state == ket_pkg::ST_IDLE, !r_chk_vld)
    `ASSERT_NEXT(a_load_sets_out, i_clk, i_rst_n, load, r_out_valid && r_state == ket_pkg::ST_IDLE)

endmodule

// File: src/ket_ram.sv
// ----------------------------------------------------------------------------
// ket_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ket_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/tb_keyed_entry_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_entry_table
// Self-checking bench for the keyed entry table. A shadow copy of the slot
// store predicts status, returned entry and occupancy for every accepted
// request; responses are compared in order. Directed requests cover the
// zero-key, duplicate, full, same-key update and empty-table cases, then
// random phases run over several capacity settings with random stalls on
// both channels, one long response hold-off and one stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyed_entry_table;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_PCT       = 30;
    localparam int TAIL_CYCLES    = 2 * ket_pkg::DEPTH + 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        ket_pkg::t_status                  status;
        logic [ket_pkg::KEY_W-1:0]         found_key;
        logic [ket_pkg::VALUE_W-1:0]       found_value;
        logic [ket_pkg::CAP_W-1:0]         entry_total;
    } t_reply;

    class t_table_shadow;
        logic [ket_pkg::KEY_W-1:0]   slot_key [ket_pkg::DEPTH];
        logic [ket_pkg::VALUE_W-1:0] slot_val [ket_pkg::DEPTH];
        int                          occupied;
        int                          active;
        t_reply                      predicted_replies [$];
        int                          mismatches;
        int                          replies_checked;
        int                          requests_noted;
        int                          status_tally [5];

        function new();
            mismatches      = 0;
            replies_checked = 0;
            requests_noted  = 0;
            foreach (status_tally[i]) begin
                status_tally[i] = 0;
            end
            set_capacity(ket_pkg::CAP_RESET);
        endfunction

        function void set_capacity(logic [ket_pkg::CAP_W-1:0] cap);
            active = (cap > ket_pkg::DEPTH) ? ket_pkg::DEPTH : int'(cap);
            foreach (slot_key[i]) begin
                slot_key[i] = '0;
                slot_val[i] = '0;
            end
            occupied = 0;
        endfunction

        function int lowest_slot(logic [ket_pkg::KEY_W-1:0] k, int skip);
            for (int i = 0; i < active; i++) begin
                if (i != skip && slot_key[i] == k) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_request(ket_pkg::t_op op, logic [ket_pkg::KEY_W-1:0] key,
                                   logic [ket_pkg::KEY_W-1:0] nkey,
                                   logic [ket_pkg::VALUE_W-1:0] val);
            t_reply r;
            int     s;
            int     t;
            r        = '0;
            r.status = ket_pkg::STATUS_OK;
            if (key == '0 || (op == ket_pkg::OP_UPDATE && nkey == '0)) begin
                r.status = ket_pkg::STATUS_ZERO_KEY;
            end else begin
                case (op)
                    ket_pkg::OP_ADD: begin
                        if (occupied >= active) begin
                            r.status = ket_pkg::STATUS_FULL;
                        end else if (lowest_slot(key, -1) >= 0) begin
                            r.status = ket_pkg::STATUS_DUP;
                        end else begin
                            s = lowest_slot('0, -1);
                            if (s < 0) begin
                                r.status = ket_pkg::STATUS_FULL;
                            end else begin
                                slot_key[s] = key;
                                slot_val[s] = val;
                                occupied++;
                            end
                        end
                    end
                    ket_pkg::OP_DELETE: begin
                        s = lowest_slot(key, -1);
                        if (s < 0) begin
                            r.status = ket_pkg::STATUS_NOT_FOUND;
                        end else begin
                            slot_key[s] = '0;
                            slot_val[s] = '0;
                            if (occupied > 0) begin
                                occupied--;
                            end
                        end
                    end
                    ket_pkg::OP_UPDATE: begin
                        s = lowest_slot(key, -1);
                        t = lowest_slot(nkey, s);
                        if (t >= 0) begin
                            r.status = ket_pkg::STATUS_DUP;
                        end else if (s < 0) begin
                            r.status = ket_pkg::STATUS_NOT_FOUND;
                        end else begin
                            slot_key[s] = nkey;
                            slot_val[s] = val;
                        end
                    end
                    default: begin
                        s = lowest_slot(key, -1);
                        if (s < 0) begin
                            r.status = ket_pkg::STATUS_NOT_FOUND;
                        end else begin
                            r.found_key   = slot_key[s];
                            r.found_value = slot_val[s];
                        end
                    end
                endcase
            end
            r.entry_total = ket_pkg::CAP_W'(occupied);
            status_tally[r.status]++;
            requests_noted++;
            predicted_replies.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("MISMATCH %s", msg);
            end
        endfunction

        function void check_response(logic [ket_pkg::STAT_W-1:0] status,
                                     logic [ket_pkg::KEY_W-1:0] fkey,
                                     logic [ket_pkg::VALUE_W-1:0] fval,
                                     logic [ket_pkg::CAP_W-1:0] total);
            t_reply want;
            replies_checked++;
            if (predicted_replies.size() == 0) begin
                flag($sformatf("response %0d with no request outstanding: status %0d",
                               replies_checked, status));
                return;
            end
            want = predicted_replies.pop_front();
            if (status !== want.status) begin
                flag($sformatf("response %0d status: expected %0d, got %0d",
                               replies_checked, want.status, status));
            end
            if (fkey !== want.found_key) begin
                flag($sformatf("response %0d found_key: expected %h, got %h",
                               replies_checked, want.found_key, fkey));
            end
            if (fval !== want.found_value) begin
                flag($sformatf("response %0d found_value: expected %h, got %h",
                               replies_checked, want.found_value, fval));
            end
            if (total !== want.entry_total) begin
                flag($sformatf("response %0d entry_total: expected %0d, got %0d",
                               replies_checked, want.entry_total, total));
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    bit                        no_idle = 1'b0;
    bit                        holdoff_request = 1'b0;
    int                        cycle_count;
    int                        capacity_writes = 0;
    logic [ket_pkg::KEY_W-1:0] key_pool [$];
    t_table_shadow             shadow = new();

    ket_item_if   item_ch ();
    ket_result_if reply_ch ();
    ket_cfg_if    cap_ch ();

    keyed_entry_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (reply_ch),
        .i_cfg    (cap_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // response side: random back-pressure, plus one long hold-off on request
    initial begin
        int holdoff_left;
        holdoff_left   = 0;
        reply_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                holdoff_left    = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                reply_ch.ready <= 1'b0;
            end else begin
                reply_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && reply_ch.valid && reply_ch.ready) begin
            shadow.check_response(reply_ch.status, reply_ch.found_key,
                                  reply_ch.found_value, reply_ch.entry_total);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 CYCLE_LIMIT, shadow.predicted_replies.size());
        $display("keyed_entry_table test failed");
        $finish;
    end

    function automatic logic [ket_pkg::KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) begin
            return '0;
        end
        if (roll < 12) begin
            return ket_pkg::KEY_W'($urandom);
        end
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    task automatic send_item(ket_pkg::t_op op, logic [ket_pkg::KEY_W-1:0] key,
                             logic [ket_pkg::KEY_W-1:0] nkey,
                             logic [ket_pkg::VALUE_W-1:0] val);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.key       <= key;
        item_ch.new_key   <= nkey;
        item_ch.value     <= val;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
        shadow.note_request(op, key, nkey, val);
    endtask

    // drop valid and hold until every response is back
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (shadow.predicted_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(logic [ket_pkg::CAP_W-1:0] cap);
        @(negedge i_clk);
        cap_ch.valid <= 1'b1;
        cap_ch.data  <= cap;
        @(posedge i_clk);
        while (!cap_ch.ready) begin
            @(posedge i_clk);
        end
        shadow.set_capacity(cap);
        capacity_writes++;
        @(negedge i_clk);
        cap_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [ket_pkg::CAP_W-1:0] cap, int count, int add_pct);
        int                        pool_len;
        int                        roll;
        int                        spread;
        logic [ket_pkg::KEY_W-1:0] k;
        ket_pkg::t_op              op;
        write_capacity(cap);
        pool_len = ((cap > ket_pkg::DEPTH) ? ket_pkg::DEPTH : int'(cap)) * 3 / 2 + 2;
        key_pool.delete();
        key_pool.push_back(ket_pkg::KEY_W'(1));
        key_pool.push_back('1);
        while (key_pool.size() < pool_len) begin
            k = ket_pkg::KEY_W'($urandom);
            if (k != '0) begin
                key_pool.push_back(k);
            end
        end
        spread = 100 - add_pct;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < add_pct) begin
                op = ket_pkg::OP_ADD;
            end else if (roll < add_pct + spread / 3) begin
                op = ket_pkg::OP_DELETE;
            end else if (roll < add_pct + 2 * spread / 3) begin
                op = ket_pkg::OP_UPDATE;
            end else begin
                op = ket_pkg::OP_GET;
            end
            send_item(op, pick_key(), pick_key(), $urandom);
        end
        settle();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = ket_pkg::OP_ADD;
        item_ch.key       = '0;
        item_ch.new_key   = '0;
        item_ch.value     = '0;
        cap_ch.valid      = 1'b0;
        cap_ch.data       = ket_pkg::CAP_RESET;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ket_pkg::OP_GET,    '0, '0, '0);
        send_item(ket_pkg::OP_ADD,    '0, 5, '1);
        send_item(ket_pkg::OP_UPDATE, 5, '0, 1);
        send_item(ket_pkg::OP_DELETE, 5, '0, '0);
        send_item(ket_pkg::OP_ADD,    1, '0, '1);
        send_item(ket_pkg::OP_ADD,    '1, '1, '0);
        send_item(ket_pkg::OP_ADD,    1, '0, 7);
        send_item(ket_pkg::OP_GET,    '1, '0, '0);
        send_item(ket_pkg::OP_UPDATE, 1, 1, 32'h1234_5678);
        send_item(ket_pkg::OP_GET,    1, '0, '0);
        send_item(ket_pkg::OP_UPDATE, 1, '1, 9);
        send_item(ket_pkg::OP_UPDATE, 99, '1, 9);
        send_item(ket_pkg::OP_UPDATE, 99, 100, 9);
        send_item(ket_pkg::OP_UPDATE, 1, 2, 32'hA5A5_5A5A);
        send_item(ket_pkg::OP_DELETE, '1, '0, '0);
        send_item(ket_pkg::OP_DELETE, '1, '0, '0);
        send_item(ket_pkg::OP_ADD,    3, '0, 32'h8000_0001);
        send_item(ket_pkg::OP_GET,    3, '0, '0);
        send_item(ket_pkg::OP_GET,    2, '0, '0);
        settle();
        write_capacity(1);
        send_item(ket_pkg::OP_ADD,    10, '0, 32'h0000_00FF);
        send_item(ket_pkg::OP_ADD,    10, '0, 32'h0000_0F00);
        send_item(ket_pkg::OP_GET,    10, '0, '0);
        settle();
        write_capacity(0);
        send_item(ket_pkg::OP_ADD,    5, '0, 1);
        send_item(ket_pkg::OP_GET,    5, '0, '0);
        settle();

        holdoff_request = 1'b1;
        run_phase(7'd4, 200, 45);
        run_phase(7'd1, 60, 45);
        run_phase(7'd64, 300, 70);
        run_phase(7'd127, 150, 50);
        run_phase(7'd0, 30, 40);
        no_idle = 1'b1;
        run_phase(7'd16, 200, 45);
        no_idle = 1'b0;
        repeat (3) begin
            run_phase(ket_pkg::CAP_W'($urandom_range(63, 2)), 120, 45);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d transactions across %0d capacity settings, %0d responses checked",
                 shadow.requests_noted, capacity_writes, shadow.replies_checked);
        $display("Outcomes: %0d ok, %0d full, %0d duplicate, %0d not found, %0d zero key",
                 shadow.status_tally[ket_pkg::STATUS_OK],
                 shadow.status_tally[ket_pkg::STATUS_FULL],
                 shadow.status_tally[ket_pkg::STATUS_DUP],
                 shadow.status_tally[ket_pkg::STATUS_NOT_FOUND],
                 shadow.status_tally[ket_pkg::STATUS_ZERO_KEY]);
        if (shadow.mismatches == 0 && shadow.predicted_replies.size() == 0) begin
            $display("keyed_entry_table test passed");
        end else begin
            $display("keyed_entry_table test failed");
        end
        $finish;
    end

endmodule
